// ===== src/mrq_pkg.sv =====
// Shared types and codes for the multi-reader ring queue.
// Holds request kinds, status codes, register indexes and the front-to-back item control word.
// No dependencies.
`default_nettype none

package mrq_pkg;

  localparam int IDX_W = 3;

  // request codes as they arrive on the input channel
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic CFG_SHARED_MODE  = 1'b0;
  localparam logic CFG_READER_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] idx;
    logic             view_ok;
  } item_ctl_t;

endpackage

`default_nettype wire

// ===== src/multi_reader_ring_queue.sv =====
// Multi-reader ring queue, top level. A request word is held in the front queue, taken by
// the back end's execute step, and its result word is registered in the finish step, which
// waits while the output side still holds an untaken result. The back end takes no new request
// until it has finished the last (execute, then finish: pointer lag flags refresh, registered store read).
// Reset (synchronous, rst_n low): pointers, lag flags, queues and handshakes
// clear; the entry store is not cleared and there is no clearing pass.
`default_nettype none

module multi_reader_ring_queue
  import mrq_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int READERS    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // tdata: write_data
  input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  // tuser: req_type [1:0], reader_index [4:2]
  input  wire logic [4:0]                            in_tuser,
  // result channel
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // tdata: read_data
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0]      out_tdata,
  // tuser: status [1:0], has_data [2]
  output logic [2:0]                                 out_tuser,
  // configuration write port
  input  wire logic                                  cfg_wr_en,
  input  wire logic                                  cfg_index,
  input  wire logic [3:0]                            cfg_wdata
);

  localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8;

  logic                  shared_mode_r;
  logic [3:0]            reader_count_r;
  logic                  q_valid, q_ready;
  item_ctl_t             q_ctl;
  logic [DATA_WIDTH-1:0] q_data;
  logic [1:0]            res_status;
  logic [DATA_WIDTH-1:0] res_rdata;
  logic                  res_has;

  // configuration registers: the user must write them only while the queue is quiet; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_mode_r  <= 1'b0;
      reader_count_r <= 4'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SHARED_MODE:  shared_mode_r  <= cfg_wdata[0];
        CFG_READER_COUNT: reader_count_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // front: take request words, classify them, hold them in a short queue
  mrq_front #(
    .READERS    (READERS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .shared_mode (shared_mode_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req      (in_tuser[1:0]),
    .in_idx      (in_tuser[4:2]),
    .in_data     (in_tdata[DATA_WIDTH-1:0]),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_ctl       (q_ctl),
    .q_data      (q_data)
  );

  // back: execute against pointers and store, hold the result word
  mrq_back #(
    .DEPTH      (DEPTH),
    .READERS    (READERS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .shared_mode  (shared_mode_r),
    .reader_count (reader_count_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_ctl        (q_ctl),
    .q_data       (q_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (res_status),
    .out_rdata    (res_rdata),
    .out_has_data (res_has)
  );

  assign out_tdata = TDW'(res_rdata);
  assign out_tuser = {res_has, res_status};

endmodule

`default_nettype wire

// ===== src/mrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module mrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/mrq_front.sv =====
// Front end: accepts request words, classifies them and holds them in a
// two-entry queue for the back end. Uses mrq_pkg.
`default_nettype none

module mrq_front
  import mrq_pkg::*;
#(
  parameter int READERS    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  shared_mode,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_req,
  input  wire logic [IDX_W-1:0]      in_idx,
  input  wire logic [DATA_WIDTH-1:0] in_data,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output item_ctl_t                  q_ctl,
  output logic [DATA_WIDTH-1:0]      q_data
);

  item_ctl_t             ctl_in;
  item_ctl_t             ctl_r  [2];
  logic [DATA_WIDTH-1:0] data_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  push, pop;

  // classify: unused code acts as a query
  always_comb begin
    unique case (in_req)
      REQ_PUSH: ctl_in.kind = KIND_PUSH;
      REQ_POP:  ctl_in.kind = KIND_POP;
      default:  ctl_in.kind = KIND_QUERY;
    endcase
    ctl_in.idx     = in_idx;
    ctl_in.view_ok = shared_mode || (32'(in_idx) < READERS);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_ctl    = ctl_r[rd_ptr_r];
  assign q_data   = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wr_ptr_r]  <= ctl_in;
      data_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/mrq_back.sv =====
// Back end: owns the write and read pointers, the per-reader lag flags and
// the entry store, executes one request and forms its result.
// Uses mrq_pkg and mrq_ram.
`default_nettype none

module mrq_back
  import mrq_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int READERS    = 8,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  shared_mode,
  input  wire logic [3:0]            reader_count,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire item_ctl_t             q_ctl,
  input  wire logic [DATA_WIDTH-1:0] q_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [DATA_WIDTH-1:0]      out_rdata,
  output logic                       out_has_data
);

  localparam int PW = $clog2(2 * DEPTH);
  localparam int AW = $clog2(DEPTH);
  localparam logic [PW:0]   PTR_MOD = (PW + 1)'(2 * DEPTH);
  localparam logic [PW-1:0] PTR_TOP = PW'(2 * DEPTH - 1);
  localparam logic [PW-1:0] LIMIT   = PW'(DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  localparam logic ST_EXEC = 1'b0;
  localparam logic ST_FIN  = 1'b1;

  function automatic logic [PW-1:0] fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] d;
    if (w >= r) d = {1'b0, w} - {1'b0, r};
    else        d = {1'b0, w} + PTR_MOD - {1'b0, r};
    return d[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PTR_TOP) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[AW-1:0];
  endfunction

  logic                  state_r, state_nxt;
  logic [PW-1:0]         wp_r, wp_nxt;
  logic [PW-1:0]         srp_r, srp_nxt;
  logic [PW-1:0]         rp_r   [READERS];
  logic [PW-1:0]         rp_nxt [READERS];
  logic [READERS-1:0]    lag_r, lag_nxt, reg_mask;
  logic                  slag_r;
  logic [1:0]            status_r;
  logic                  pop_ok_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  view_ok_r;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [DATA_WIDTH-1:0] out_rdata_r;
  logic                  out_has_r;
  logic [PW-1:0]         vptr_q, vptr_f;
  logic [3:0]            ncnt;
  logic                  full, take, finish, push_ok, pop_ok, has_f;
  logic [1:0]            status_q;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // registered readers: reader_count 0 counts as 1, lanes cap the top end
  always_comb begin
    ncnt = (reader_count == 4'd0) ? 4'd1 : reader_count;
    for (int i = 0; i < READERS; i++) begin
      reg_mask[i] = 32'(i) < 32'(ncnt);
    end
  end

  // view pointer for the queued request and for the request in flight
  always_comb begin
    vptr_q = srp_r;
    vptr_f = srp_r;
    if (!shared_mode) begin
      vptr_q = '0;
      vptr_f = '0;
      for (int i = 0; i < READERS; i++) begin
        if (32'(i) == 32'(q_ctl.idx)) vptr_q = rp_r[i];
        if (32'(i) == 32'(idx_r))     vptr_f = rp_r[i];
      end
    end
  end

  assign full    = shared_mode ? slag_r : |(lag_r & reg_mask);
  assign q_ready = (state_r == ST_EXEC);
  assign take    = q_valid && q_ready;
  assign finish  = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign push_ok = (q_ctl.kind == KIND_PUSH) && !full;
  assign pop_ok  = (q_ctl.kind == KIND_POP) && q_ctl.view_ok && (fill(wp_r, vptr_q) != '0);
  assign has_f   = view_ok_r && (fill(wp_r, vptr_f) != '0);

  always_comb begin
    if ((q_ctl.kind == KIND_PUSH) && full)                      status_q = STAT_FULL;
    else if ((q_ctl.kind == KIND_POP) && !pop_ok)               status_q = STAT_EMPTY;
    else                                                        status_q = STAT_DONE;
  end

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    srp_nxt   = srp_r;
    for (int i = 0; i < READERS; i++) begin
      rp_nxt[i]  = rp_r[i];
      lag_nxt[i] = fill(wp_r, rp_r[i]) >= LIMIT;
    end
    unique case (state_r)
      ST_EXEC: begin
        if (take) begin
          state_nxt = ST_FIN;
          if (push_ok) wp_nxt = inc(wp_r);
          if (pop_ok) begin
            if (shared_mode) srp_nxt = inc(srp_r);
            else begin
              for (int i = 0; i < READERS; i++) begin
                if (32'(i) == 32'(q_ctl.idx)) rp_nxt[i] = inc(rp_r[i]);
              end
            end
          end
        end
      end
      default: begin
        if (finish) state_nxt = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      wp_r        <= '0;
      srp_r       <= '0;
      lag_r       <= '0;
      slag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < READERS; i++) rp_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      srp_r   <= srp_nxt;
      lag_r   <= lag_nxt;
      slag_r  <= fill(wp_r, srp_r) >= LIMIT;
      for (int i = 0; i < READERS; i++) rp_r[i] <= rp_nxt[i];
      if (finish)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r  <= status_q;
      pop_ok_r  <= pop_ok;
      idx_r     <= q_ctl.idx;
      view_ok_r <= q_ctl.view_ok;
    end
    if (finish) begin
      out_status_r <= status_r;
      out_rdata_r  <= pop_ok_r ? ram_rdata : '0;
      out_has_r    <= has_f;
    end
  end

  mrq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (take && push_ok),
    .waddr   (slot(wp_r)),
    .wdata   (q_data),
    .re      (take && pop_ok),
    .raddr   (slot(vptr_q)),
    .rdata_r (ram_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_rdata    = out_rdata_r;
  assign out_has_data = out_has_r;

endmodule

`default_nettype wire

// ===== tb/sv/multi_reader_ring_queue_test.sv =====
// Self-checking testbench for the multi-reader ring queue: drives request words and register
// writes, predicts every reply in a small board class and compares replies field by field.
// Depends on mrq_pkg and multi_reader_ring_queue from the RTL.
module multi_reader_ring_queue_test;
  import mrq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 1024;
  localparam int READERS    = 8;
  localparam int DATA_WIDTH = 32;

  // request code with no operation of its own: behaves as a query
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off while the store fills
  localparam int IDLE_LIMIT   = 3000;  // cycles without any handshake before giving up
  localparam int TAIL_CYCLES  = 8;     // settle time after the last reply
  localparam int ITEM_TARGET  = 1450;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic        has_data;
  } reply_t;

  // Board: private copy of the queue state, the expected replies and the mismatch count.
  class ring_queue_board;
    logic [31:0] words [DEPTH];
    logic [10:0] wr_ptr;
    logic [10:0] rd_ptr [READERS];
    logic [10:0] shared_ptr;
    bit          shared_mode;
    logic [3:0]  reader_count;
    reply_t      expected_replies [$];
    int          errors;
    int          stored;
    int          refused_full;
    int          popped;
    int          refused_empty;

    function void clear();
      wr_ptr       = '0;
      shared_ptr   = '0;
      shared_mode  = 1'b0;
      reader_count = 4'd1;
      foreach (rd_ptr[i]) rd_ptr[i] = '0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void write_reg(logic index, logic [3:0] value);
      if (index == CFG_SHARED_MODE) shared_mode = value[0];
      else reader_count = value;
    endfunction

    // pointers run modulo 2*DEPTH, which is the natural wrap of 11 bits
    function logic [10:0] lag(logic [10:0] rp);
      return wr_ptr - rp;
    endfunction

    function bit at_capacity();
      int n;
      if (shared_mode) return lag(shared_ptr) >= DEPTH - 1;
      n = reader_count;
      if (n == 0) n = 1;
      if (n > READERS) n = READERS;
      for (int i = 0; i < n; i++)
        if (lag(rd_ptr[i]) >= DEPTH - 1) return 1'b1;
      return 1'b0;
    endfunction

    // Work out the reply to one accepted request and queue it.
    function void note_request(logic [1:0] req, logic [2:0] idx, logic [31:0] data);
      reply_t      r;
      bit          view_ok;
      logic [10:0] rp;
      r       = '0;
      view_ok = shared_mode || (int'(idx) < READERS);
      rp      = shared_mode ? shared_ptr : (view_ok ? rd_ptr[idx] : '0);
      case (req)
        REQ_PUSH: begin
          if (at_capacity()) begin
            r.status = STAT_FULL;
            refused_full++;
          end else begin
            words[wr_ptr % DEPTH] = data;
            wr_ptr = wr_ptr + 11'd1;
            stored++;
          end
        end
        REQ_POP: begin
          if (!view_ok || lag(rp) == 0) begin
            r.status = STAT_EMPTY;
            refused_empty++;
          end else begin
            r.read_data = words[rp % DEPTH];
            rp = rp + 11'd1;
            if (shared_mode) shared_ptr = rp;
            else rd_ptr[idx] = rp;
            popped++;
          end
        end
        default: ;  // query and the spare code change nothing
      endcase
      r.has_data = view_ok && (lag(rp) != 0);
      expected_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_reply(logic [2:0] tuser, logic [31:0] tdata);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply with nothing pending: status %0d data %h has_data %0d",
                         tuser[1:0], tdata, tuser[2]));
        return;
      end
      want = expected_replies.pop_front();
      if (tuser[1:0] !== want.status)
        report($sformatf("status %0d, expected %0d", tuser[1:0], want.status));
      if (tdata !== want.read_data)
        report($sformatf("read_data %h, expected %h", tdata, want.read_data));
      if (tuser[2] !== want.has_data)
        report($sformatf("has_data %0d, expected %0d", tuser[2], want.has_data));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;     // req_type [1:0], reader_index [4:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // read_data
  logic [2:0]  out_tuser;         // status [1:0], has_data [2]
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [3:0]  cfg_wdata = '0;

  ring_queue_board board;
  int  requests_sent;
  int  in_calm;                   // words left in a run with no sender gaps
  int  out_calm;                  // replies left in a run with no receiver stalls
  bit  hold_replies;              // ask the receiver for one long hold-off
  int  idle_cycles;

  multi_reader_ring_queue #(
    .DEPTH     (DEPTH),
    .READERS   (READERS),
    .DATA_WIDTH(DATA_WIDTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Gap before the next word on one side: usually drawn at random, with occasional runs of none.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Offer one request word and hold it until accepted. Valid stays high when no gap follows,
  // so it is never lowered and raised in the same step.
  task automatic send_request(logic [1:0] req, logic [2:0] idx, logic [31:0] data);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {idx, req};
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    board.note_request(req, idx, data);
    requests_sent++;
  endtask

  // Drop valid and hold until every expected reply has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.expected_replies.size() != 0) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; the block is idle whenever this runs.
  task automatic set_config(logic [3:0] mode_word, logic [3:0] count_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SHARED_MODE;
    cfg_wdata <= mode_word;
    @(posedge clk);
    board.write_reg(CFG_SHARED_MODE, mode_word);
    cfg_index <= CFG_READER_COUNT;
    cfg_wdata <= count_word;
    @(posedge clk);
    board.write_reg(CFG_READER_COUNT, count_word);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic next_phase(bit shared, logic [3:0] count_word);
    wait_drained();
    // upper bits of the mode word are don't-care; toggle them anyway
    set_config({3'($urandom_range(0, 7)), shared}, count_word);
  endtask

  // Random mix; narrow aims most reader indexes at readers 0 and 1 so their views drain.
  task automatic random_requests(int count, int push_pct, int pop_pct, bit narrow);
    int          roll;
    logic [1:0]  req;
    logic [2:0]  idx;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) req = REQ_PUSH;
      else if (roll < push_pct + pop_pct) req = REQ_POP;
      else if (roll < 95) req = REQ_QUERY;
      else req = REQ_SPARE;
      if (narrow && $urandom_range(0, 3) != 0) idx = 3'($urandom_range(0, 1));
      else idx = 3'($urandom_range(0, 7));
      send_request(req, idx, $urandom);
    end
  endtask

  // Receiver: stall at random before each reply, plus one long hold-off on request.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_replies) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_replies = 1'b0;
      end
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      board.check_reply(out_tuser, out_tdata);
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int target;
    int guard;
    board = new;
    board.clear();
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: broadcast mode, one registered reader (reset values).
    send_request(REQ_QUERY, 3'd0, 32'h0);           // empty view
    send_request(REQ_POP,   3'd0, 32'h0);           // pop from empty
    send_request(REQ_POP,   3'd7, 32'h0);           // highest reader, empty
    send_request(REQ_SPARE, 3'd5, 32'hFFFF_FFFF);   // spare code acts as a query
    send_request(REQ_PUSH,  3'd0, 32'h0000_0000);
    send_request(REQ_PUSH,  3'd7, 32'hFFFF_FFFF);
    send_request(REQ_PUSH,  3'd2, 32'hA5A5_A5A5);
    send_request(REQ_QUERY, 3'd3, 32'h0);
    send_request(REQ_POP,   3'd0, 32'h0);
    send_request(REQ_POP,   3'd7, 32'h0);           // unregistered reader still sees entries
    send_request(REQ_POP,   3'd0, 32'h0);
    send_request(REQ_POP,   3'd0, 32'h0);
    send_request(REQ_POP,   3'd0, 32'h0);           // drained: refused as empty
    send_request(REQ_QUERY, 3'd0, 32'h0);

    // Shared pointer, reader count zero (treated as one).
    next_phase(1'b1, 4'd0);
    send_request(REQ_QUERY, 3'd6, 32'h0);
    send_request(REQ_POP,   3'd2, 32'h0);
    send_request(REQ_POP,   3'd5, 32'h0);
    send_request(REQ_POP,   3'd0, 32'h0);
    send_request(REQ_POP,   3'd7, 32'h0);           // shared view empty
    send_request(REQ_PUSH,  3'd7, 32'h5A5A_5A5A);
    send_request(REQ_SPARE, 3'd0, 32'h0);
    send_request(REQ_QUERY, 3'd4, 32'h0);

    // Back to per-reader pointers with an oversized count: old pointers are picked up again.
    next_phase(1'b0, 4'd15);
    send_request(REQ_POP,   3'd7, 32'h0);
    send_request(REQ_POP,   3'd3, 32'h0);

    // Low occupancy: pop-heavy mixes so views keep running empty in both modes.
    for (int p = 0; p < 6; p++) begin
      next_phase(p[0], 4'($urandom_range(1, 8)));
      random_requests(50, 35, 50, 1'b1);
    end

    // Fill: eight registered readers, pushes until refusals show up. The receiver holds off
    // for a long stretch early on so the block backs up and stalls its input.
    next_phase(1'b0, 4'd8);
    target = board.refused_full + 3;
    guard  = 0;
    while (board.refused_full < target && guard < 1200) begin
      if (guard == 20) hold_replies = 1'b1;
      send_request(REQ_PUSH, 3'($urandom_range(0, 7)), $urandom);
      guard++;
    end

    // Full check must cover every registered reader, the last one included.
    wait_drained();
    send_request(REQ_PUSH, 3'd0, $urandom);
    for (int r = 0; r < READERS - 1; r++) send_request(REQ_POP, 3'(r), 32'h0);
    send_request(REQ_PUSH, 3'd1, $urandom);
    send_request(REQ_POP,  3'd7, 32'h0);
    send_request(REQ_PUSH, 3'd2, $urandom);
    send_request(REQ_PUSH, 3'd3, $urandom);

    // Count zero guards reader 0 only; the others are lapped freely.
    next_phase(1'b0, 4'd0);
    send_request(REQ_POP,   3'd0, 32'h0);
    send_request(REQ_POP,   3'd0, 32'h0);
    send_request(REQ_PUSH,  3'd4, $urandom);
    send_request(REQ_PUSH,  3'd5, $urandom);
    send_request(REQ_QUERY, 3'd6, 32'h0);

    // Shared pointer far behind: full in shared mode.
    next_phase(1'b1, 4'd9);
    send_request(REQ_PUSH, 3'd0, $urandom);
    send_request(REQ_POP,  3'd3, 32'h0);
    send_request(REQ_POP,  3'd6, 32'h0);
    send_request(REQ_PUSH, 3'd1, $urandom);
    send_request(REQ_PUSH, 3'd2, $urandom);

    // High occupancy: random mixes under random settings until the item budget is spent.
    do begin
      case ($urandom_range(0, 4))
        0: next_phase(1'($urandom_range(0, 1)), 4'd0);
        1: next_phase(1'($urandom_range(0, 1)), 4'd1);
        2: next_phase(1'($urandom_range(0, 1)), 4'd8);
        3: next_phase(1'($urandom_range(0, 1)), 4'd15);
        default: next_phase(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      endcase
      random_requests(50, 45, 40, 1'b0);
    end while (requests_sent < ITEM_TARGET);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.expected_replies.size() != 0)
      board.report($sformatf("%0d replies never arrived", board.expected_replies.size()));

    $display("Ran %0d requests: %0d pushes stored, %0d refused as full, %0d pops served,",
             requests_sent, board.stored, board.refused_full, board.popped);
    $display("%0d refused as empty, over per-reader and shared modes with 0..15 readers.",
             board.refused_empty);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/mrq_pkg.sv
src/mrq_ram.sv
src/mrq_front.sv
src/mrq_back.sv
src/multi_reader_ring_queue.sv
tb/sv/multi_reader_ring_queue_test.sv
